// ===== rtl/tsf_pkg.sv =====
// Shared types and constants for the touch sample filter and calibrator.
package tsf_pkg;

    localparam int SAMPLES_DEF = 7;
    localparam int DISCARD_DEF = 2;

    localparam int SAMPLE_BITS = 12;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 12'h0fff;

    localparam int COORD_W    = 12;
    localparam int COORD_FRAC = 12;
    localparam int SCALE_W    = 16;
    localparam int PRESS_W    = 13;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    localparam logic [SAMPLE_BITS-1:0] X_ZERO_RST  = 12'd3860;
    localparam logic [SAMPLE_BITS-1:0] Y_ZERO_RST  = 12'd370;
    localparam logic [SCALE_W-1:0]     X_SCALE_RST = 16'hFE8C;   // -372
    localparam logic [SCALE_W-1:0]     Y_SCALE_RST = 16'd283;
    localparam logic [COORD_W-1:0]     X_LIMIT_RST = 12'd319;
    localparam logic [COORD_W-1:0]     Y_LIMIT_RST = 12'd239;
    localparam logic [PRESS_W-1:0]     PRESS_RST   = 13'd550;

    typedef enum logic [1:0] {
        CH_X  = 2'd0,
        CH_Y  = 2'd1,
        CH_Z1 = 2'd2,
        CH_Z2 = 2'd3
    } t_chan;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_ZERO   = 3'd0,
        CFG_Y_ZERO   = 3'd1,
        CFG_X_SCALE  = 3'd2,
        CFG_Y_SCALE  = 3'd3,
        CFG_SWAP_XY  = 3'd4,
        CFG_X_LIMIT  = 3'd5,
        CFG_Y_LIMIT  = 3'd6,
        CFG_PRESS    = 3'd7
    } t_cfg_idx;

    // per-cell insert control
    typedef struct packed {
        logic en;    // a word is taken this cycle
        logic occ;   // cell holds a sample of the current run
        logic tail;  // cell is the first free slot
    } t_cell_ctl;

endpackage

// ===== rtl/tsf_cell.sv =====
// One slot of the sorted sample row: compare, hold or shift from the left.
module tsf_cell
    import tsf_pkg::*;
(
    input  logic                   i_clk,
    input  t_cell_ctl              i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_left_val,
    input  logic                   i_left_gt,
    output logic [SAMPLE_BITS-1:0] o_val,
    output logic                   o_gt
);

    logic [SAMPLE_BITS-1:0] r_val;
    logic [SAMPLE_BITS-1:0] n_val;
    logic                   gt_self;
    logic                   wr;

    assign gt_self = i_ctl.occ && (r_val > i_sample);
    assign wr      = i_ctl.en && (i_ctl.tail || gt_self);
    // left neighbor moved right too: take its old value, else the new sample lands here
    assign n_val   = i_left_gt ? i_left_val : i_sample;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;
    assign o_gt  = gt_self;

endmodule

// ===== rtl/touch_sample_filter_calibrate_unit.sv =====
// Top level: sorted-insert cell row, trimmed mean and screen calibration pipeline.
// Throughput: one sample word per cycle while s_axis_tready is high; one result per
//   SAMPLES samples of a channel. The edge that takes the run's last sample inserts it,
//   then the middle sum, reciprocal multiply, offset times scale, and truncate and clamp
//   are registered in turn.
// A stalled result only blocks input when a finished run cannot leave the sort row.
// Reset (synchronous, active low) clears run count, channel, Z1 mean and valids, and
//   reloads the calibration defaults.
module touch_sample_filter_calibrate_unit
    import tsf_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF,
    parameter int DISCARD = DISCARD_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [11:0] sample, [12] pen_irq_low
    input  logic [1:0]             s_axis_tuser,   // [1:0] channel

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [11:0] filtered, [12] coord_axis,
                                                   // [24:13] coord, [25] pressed
    output logic [1:0]             m_axis_tuser,   // [1:0] out_channel

    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // trim depth shrinks so at least one sample survives
    localparam int EFF_D   = (2 * DISCARD < SAMPLES) ? DISCARD : (SAMPLES - 1) / 2;
    localparam int KEEP    = SAMPLES - 2 * EFF_D;
    localparam int CNT_W   = $clog2(SAMPLES);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(KEEP);
    // mean = (sum * RECIP) >> RSH, exact for every sum below 2^SUM_W
    localparam int RSH     = SUM_W + $clog2(KEEP);
    localparam int RECIP_W = RSH + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RSH) / KEEP + 1);
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int MAP_W   = DIFF_W + SCALE_W;
    localparam logic [MAP_W-1:0] FRAC_MASK = MAP_W'((2 ** COORD_FRAC) - 1);

    // ---------------- configuration ----------------
    logic [SAMPLE_BITS-1:0]   r_x_zero, r_y_zero;
    logic signed [SCALE_W-1:0] r_x_scale, r_y_scale;
    logic                     r_swap;
    logic [COORD_W-1:0]       r_x_limit, r_y_limit;
    logic [PRESS_W-1:0]       r_press_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_zero    <= X_ZERO_RST;
            r_y_zero    <= Y_ZERO_RST;
            r_x_scale   <= X_SCALE_RST;
            r_y_scale   <= Y_SCALE_RST;
            r_swap      <= 1'b0;
            r_x_limit   <= X_LIMIT_RST;
            r_y_limit   <= Y_LIMIT_RST;
            r_press_min <= PRESS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_X_ZERO:  r_x_zero    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_Y_ZERO:  r_y_zero    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_X_SCALE: r_x_scale   <= i_cfg_data[SCALE_W-1:0];
                CFG_Y_SCALE: r_y_scale   <= i_cfg_data[SCALE_W-1:0];
                CFG_SWAP_XY: r_swap      <= i_cfg_data[0];
                CFG_X_LIMIT: r_x_limit   <= i_cfg_data[COORD_W-1:0];
                CFG_Y_LIMIT: r_y_limit   <= i_cfg_data[COORD_W-1:0];
                CFG_PRESS:   r_press_min <= i_cfg_data[PRESS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake / stage readiness ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_ov;
    logic rdy1, rdy2, rdy3, rdy4, rdy_o;

    // each stage moves when the next one has room or moves too
    assign rdy_o = !r_ov || m_axis_tready;
    assign rdy4  = !r_v4 || rdy_o;
    assign rdy3  = !r_v3 || rdy4;
    assign rdy2  = !r_v2 || rdy3;
    // a finished run sitting in the row must be summed before the row changes
    assign rdy1  = !r_v1 || rdy2;
    assign s_axis_tready = rdy1;

    logic                   in_acc;
    logic [SAMPLE_BITS-1:0] in_sample;
    t_chan                  in_ch;
    logic                   in_irq;

    assign in_acc    = s_axis_tvalid && rdy1;
    assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_irq    = s_axis_tdata[SAMPLE_BITS];
    assign in_ch     = t_chan'(s_axis_tuser);

    // ---------------- run tracking ----------------
    logic [CNT_W-1:0] r_cnt;
    t_chan            r_run_ch;
    logic [CNT_W-1:0] eff_cnt;
    logic             run_done;

    // a channel change drops the partial run
    assign eff_cnt  = (r_cnt != '0 && in_ch != r_run_ch) ? '0 : r_cnt;
    assign run_done = (eff_cnt == CNT_W'(SAMPLES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_run_ch <= CH_X;
        end else if (in_acc) begin
            r_cnt <= run_done ? '0 : eff_cnt + CNT_W'(1);
            if (eff_cnt == '0) begin
                r_run_ch <= in_ch;
            end
        end
    end

    // ---------------- sorted insert row ----------------
    logic [SAMPLE_BITS-1:0] cell_val [SAMPLES];
    logic                   cell_gt  [SAMPLES];

    genvar gi;
    generate
        for (gi = 0; gi < SAMPLES; gi++) begin : g_cell
            t_cell_ctl              ctl;
            logic [SAMPLE_BITS-1:0] left_val;
            logic                   left_gt;

            assign ctl.en   = in_acc;
            assign ctl.occ  = eff_cnt > CNT_W'(gi);
            assign ctl.tail = eff_cnt == CNT_W'(gi);

            if (gi == 0) begin : g_head
                assign left_val = '0;
                assign left_gt  = 1'b0;
            end else begin : g_link
                assign left_val = cell_val[gi-1];
                assign left_gt  = cell_gt[gi-1];
            end

            tsf_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_sample   (in_sample),
                .i_left_val (left_val),
                .i_left_gt  (left_gt),
                .o_val      (cell_val[gi]),
                .o_gt       (cell_gt[gi])
            );
        end
    endgenerate

    // stage 1: finished run waiting in the row
    t_chan r_ch1;
    logic  r_irq1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= in_acc && run_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && run_done) begin
            r_ch1  <= in_ch;
            r_irq1 <= in_irq;
        end
    end

    // ---------------- stage 2: sum of the middle slots ----------------
    logic [SUM_W-1:0] mid_sum;

    always_comb begin
        mid_sum = '0;
        for (int k = EFF_D; k < SAMPLES - EFF_D; k++) begin
            mid_sum = mid_sum + SUM_W'(cell_val[k]);
        end
    end

    logic [SUM_W-1:0] r_sum2;
    t_chan            r_ch2;
    logic             r_irq2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_sum2 <= mid_sum;
            r_ch2  <= r_ch1;
            r_irq2 <= r_irq1;
        end
    end

    // ---------------- stage 3: divide by KEEP via reciprocal ----------------
    logic [PROD_W-1:0] r_prod3;
    t_chan             r_ch3;
    logic              r_irq3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_prod3 <= PROD_W'(r_sum2) * PROD_W'(RECIP);
            r_ch3   <= r_ch2;
            r_irq3  <= r_irq2;
        end
    end

    // ---------------- stage 4: offset, scale, pressure ----------------
    logic [SAMPLE_BITS-1:0]    mean3;
    logic                      pos3, to_x3;
    logic [SAMPLE_BITS-1:0]    zero3;
    logic signed [SCALE_W-1:0] scale3;
    logic signed [DIFF_W-1:0]  diff3;
    logic signed [MAP_W-1:0]   map3;
    logic [PRESS_W-1:0]        zsum3;
    logic                      pressed3;
    logic [SAMPLE_BITS-1:0]    r_z1;

    assign mean3  = r_prod3[RSH +: SAMPLE_BITS];
    assign pos3   = (r_ch3 == CH_X) || (r_ch3 == CH_Y);
    // default routing sends raw Y to screen x
    assign to_x3  = r_swap ? (r_ch3 == CH_X) : (r_ch3 == CH_Y);
    assign zero3  = to_x3 ? r_x_zero : r_y_zero;
    assign scale3 = to_x3 ? r_x_scale : r_y_scale;
    assign diff3  = signed'({1'b0, mean3}) - signed'({1'b0, zero3});
    assign map3   = MAP_W'(diff3) * MAP_W'(scale3);
    // z1 + full scale - z2 never goes negative
    assign zsum3  = PRESS_W'(r_z1) + PRESS_W'(SAMPLE_MAX) - PRESS_W'(mean3);
    assign pressed3 = (r_ch3 == CH_Z2) && (r_irq3 || (zsum3 > r_press_min));

    logic [SAMPLE_BITS-1:0]  r_mean4;
    t_chan                   r_ch4;
    logic                    r_pos4;
    logic                    r_axis4;
    logic signed [MAP_W-1:0] r_map4;
    logic                    r_pressed4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_z1 <= '0;
        end else begin
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy4 && r_v3 && r_ch3 == CH_Z1) begin
                r_z1 <= mean3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            r_mean4    <= mean3;
            r_ch4      <= r_ch3;
            r_pos4     <= pos3;
            r_axis4    <= pos3 && !to_x3;
            r_map4     <= map3;
            r_pressed4 <= pressed3;
        end
    end

    // ---------------- stage 5: truncate toward zero, clamp, output ----------------
    logic signed [MAP_W-1:0] rnd4;
    logic signed [MAP_W-1:0] q4;
    logic [COORD_W-1:0]      limit4;
    logic [COORD_W-1:0]      coord4;

    assign rnd4   = r_map4 + (r_map4[MAP_W-1] ? signed'(FRAC_MASK) : signed'(MAP_W'(0)));
    assign q4     = rnd4 >>> COORD_FRAC;
    assign limit4 = r_axis4 ? r_y_limit : r_x_limit;

    always_comb begin
        if (!r_pos4 || q4 < 0) begin
            coord4 = '0;
        end else if (q4 > signed'(MAP_W'(limit4))) begin
            coord4 = limit4;
        end else begin
            coord4 = q4[COORD_W-1:0];
        end
    end

    logic [SAMPLE_BITS-1:0] r_o_mean;
    t_chan                  r_o_ch;
    logic                   r_o_axis;
    logic [COORD_W-1:0]     r_o_coord;
    logic                   r_o_pressed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (rdy_o) begin
            r_ov <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o && r_v4) begin
            r_o_mean    <= r_mean4;
            r_o_ch      <= r_ch4;
            r_o_axis    <= r_axis4;
            r_o_coord   <= coord4;
            r_o_pressed <= r_pressed4;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_o_ch;
    assign m_axis_tdata  = {
        (OUT_TDATA_W - SAMPLE_BITS - COORD_W - 2)'(0),
        r_o_pressed,
        r_o_coord,
        r_o_axis,
        r_o_mean
    };

endmodule
